>>> hdl/rawds_pkg.sv
// Package: constants, types and helpers for the range-assign digit-sum core.
`default_nettype none
package rawds_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned VAL_W      = 30;
  localparam int unsigned WIDE_W     = 34;
  localparam logic [VAL_W-1:0] PRIME = 30'd998244353;
  localparam logic [DIGIT_W-1:0] RESET_DIGIT = 4'd1;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT   = 4'd9;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic load;
    logic rd_en;
    logic acc_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } sts_t;

  // acc*10 + digit, reduced mod PRIME (acc < PRIME)
  function automatic logic [VAL_W-1:0] horner_step(input logic [VAL_W-1:0] acc,
                                                    input logic [DIGIT_W-1:0] dig);
    logic [WIDE_W-1:0] x;
    logic [WIDE_W-1:0] kp;
    logic [VAL_W-1:0]  r;
    x = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {30'd0, dig};
    r = x[VAL_W-1:0];
    for (int k = 0; k < 10; k++) begin
      kp = WIDE_W'(k) * {4'd0, PRIME};
      if (x >= kp) begin
        r = VAL_W'(x - kp);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rawds_dp.sv
// Datapath: digit memory, position counter, Horner accumulator, result register.
`default_nettype none
module rawds_dp
  import rawds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               cfg_wr_en,
  input  wire logic [POS_W-1:0]   cfg_wr_data,
  input  wire logic [POS_W-1:0]   in_range_low,
  input  wire logic [POS_W-1:0]   in_range_high,
  input  wire logic [DIGIT_W-1:0] in_digit,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VAL_W-1:0]        out_number_mod_p
);

  logic [DIGIT_W-1:0] mem [MAX_LENGTH];

  logic [POS_W-1:0]   len_r, len_nxt;
  logic [POS_W-1:0]   cnt_r;
  logic [POS_W-1:0]   lo_r, hi_r;
  logic [DIGIT_W-1:0] d_r;
  logic               upd_r;
  logic               s_vld_r;
  logic [POS_W-1:0]   s_pos_r;
  logic [DIGIT_W-1:0] rd_r;
  logic [VAL_W-1:0]   acc_r;
  logic               out_vld_r;
  logic [VAL_W-1:0]   out_r;
  logic               in_rng;
  logic [DIGIT_W-1:0] eff;
  logic               upd_ok;

  always_comb begin
    len_nxt = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      len_nxt = POS_W'(1);
    end else if (cfg_wr_data > POS_W'(MAX_LENGTH)) begin
      len_nxt = POS_W'(MAX_LENGTH);
    end
  end

  assign upd_ok = (in_digit >= 4'd1) && (in_digit <= MAX_DIGIT) &&
                  (in_range_low <= in_range_high) && (in_range_high != '0) &&
                  (in_range_low <= len_r);

  assign in_rng = upd_r && (s_pos_r >= lo_r) && (s_pos_r <= hi_r);
  assign eff    = in_rng ? d_r : rd_r;

  assign sts.cnt_last = (cnt_r == len_r);
  assign sts.out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= POS_W'(MAX_LENGTH);
      cnt_r     <= POS_W'(1);
      upd_r     <= 1'b0;
      s_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= len_nxt;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= POS_W'(1);
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + POS_W'(1);
      end
      if (cmd.load) begin
        upd_r <= upd_ok;
      end
      s_vld_r <= cmd.rd_en;
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r <= in_range_low;
      hi_r <= in_range_high;
      d_r  <= in_digit;
    end
    if (cmd.rd_en) begin
      s_pos_r <= cnt_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (s_vld_r) begin
      acc_r <= horner_step(acc_r, eff);
    end
    if (cmd.out_load) begin
      out_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[cnt_r[ADDR_W-1:0] - ADDR_W'(1)] <= RESET_DIGIT;
    end else if (s_vld_r && in_rng) begin
      mem[s_pos_r[ADDR_W-1:0] - ADDR_W'(1)] <= d_r;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[cnt_r[ADDR_W-1:0] - ADDR_W'(1)];
    end
  end

  assign out_valid        = out_vld_r;
  assign out_number_mod_p = out_r;

endmodule
`default_nettype wire

>>> hdl/rawds_ctrl.sv
// Controller: clear pass, scan sequencing and result hand-off.
`default_nettype none
module rawds_ctrl
  import rawds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_wr_en) begin
      state_nxt = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: if (sts.cnt_last) state_nxt = ST_IDLE;
        ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
        ST_SCAN:  if (sts.cnt_last) state_nxt = ST_DRAIN;
        ST_DRAIN: state_nxt = ST_DONE;
        ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
        default:  state_nxt = ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    if (cfg_wr_en) begin
      cmd.cnt_clr = 1'b1;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          cmd.clr_wr  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
        ST_IDLE: begin
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.load    = 1'b1;
            cmd.cnt_clr = 1'b1;
            cmd.acc_clr = 1'b1;
          end
        end
        ST_SCAN: begin
          cmd.rd_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
        ST_DRAIN: begin
        end
        ST_DONE: begin
          cmd.out_load = sts.out_free;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/range_assign_weighted_digit_sum_core.sv
// The scan reads one digit per cycle from the digit memory into the Horner accumulator.
// A new input is taken only in idle, after the scan and the hand-off of the last result.
// Reset and every length write start a clearing pass that sets digits 1 to length to
// one; no input is taken during it. rst_n sets the length to 4096 and clears result valid.
// Top level: range-assign decimal string, value mod 998244353.
`default_nettype none
module range_assign_weighted_digit_sum_core
  import rawds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [POS_W-1:0]   cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [POS_W-1:0]   in_range_low,
  input  wire logic [POS_W-1:0]   in_range_high,
  input  wire logic [DIGIT_W-1:0] in_digit,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VAL_W-1:0]        out_number_mod_p
);

  cmd_t cmd;
  sts_t sts;

  rawds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rawds_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .in_digit        (in_digit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_number_mod_p(out_number_mod_p)
  );

endmodule
`default_nettype wire

>>> hdl/rawds_checker.sv
// Port-level checker for the range-assign digit-sum core, with its bind.
`default_nettype none
module rawds_checker
  import rawds_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             cfg_wr_en,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [VAL_W-1:0] out_number_mod_p
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_number_mod_p))
    else $error("stalled result changed");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_number_mod_p < PRIME)
    else $error("result not reduced");

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken during scan");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> in_stall)
    else $error("input taken right after length write");

endmodule

bind range_assign_weighted_digit_sum_core rawds_checker u_rawds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_wr_en       (cfg_wr_en),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_number_mod_p(out_number_mod_p)
);
`default_nettype wire

>>> tb/range_assign_weighted_digit_sum_core_test.sv
// Testbench for the range-assign digit-sum core: predicts every result, checks it in order.
`timescale 1ns / 1ps
module range_assign_weighted_digit_sum_core_test;
  import rawds_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int FIFO_DEPTH = 64;
  localparam longint MODULUS = longint'(PRIME);

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [POS_W-1:0]   cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [POS_W-1:0]   in_range_low;
  logic [POS_W-1:0]   in_range_high;
  logic [DIGIT_W-1:0] in_digit;
  logic               out_valid;
  logic               out_stall;
  logic [VAL_W-1:0]   out_number_mod_p;

  range_assign_weighted_digit_sum_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_range_low(in_range_low), .in_range_high(in_range_high), .in_digit(in_digit),
    .out_valid(out_valid), .out_stall(out_stall), .out_number_mod_p(out_number_mod_p)
  );

  // shadow digit string and expected values
  logic [DIGIT_W-1:0] shadow_digit [1:MAX_LENGTH];
  int unsigned        shadow_len;
  logic [VAL_W-1:0]   want_fifo [0:FIFO_DEPTH-1];
  int unsigned        fifo_wr;
  int unsigned        fifo_rd;

  int  errors;
  int  items_sent;
  int  values_seen;
  int  lengths_used;
  int  idle_cycles;
  int  hold_cycles;
  bit  quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void restore_ones(input logic [POS_W-1:0] raw);
    int unsigned v;
    v = raw;
    if (v < 1) v = 1;
    if (v > MAX_LENGTH) v = MAX_LENGTH;
    shadow_len = v;
    for (int i = 1; i <= MAX_LENGTH; i++) shadow_digit[i] = RESET_DIGIT;
  endfunction

  function automatic logic [VAL_W-1:0] assign_and_value(input logic [POS_W-1:0] lo_in,
      input logic [POS_W-1:0] hi_in, input logic [DIGIT_W-1:0] d);
    int unsigned lo;
    int unsigned hi;
    longint acc;
    lo = lo_in;
    hi = hi_in;
    if (d >= 1 && d <= MAX_DIGIT && lo <= hi && hi >= 1 && lo <= shadow_len) begin
      if (lo < 1) lo = 1;
      if (hi > shadow_len) hi = shadow_len;
      for (int unsigned i = lo; i <= hi; i++) shadow_digit[i] = d;
    end
    acc = 0;
    for (int unsigned i = 1; i <= shadow_len; i++)
      acc = (acc * 10 + longint'(shadow_digit[i])) % MODULUS;
    return VAL_W'(acc);
  endfunction

  function automatic int unsigned fifo_count();
    return fifo_wr - fifo_rd;
  endfunction

  task automatic send_item(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                           input logic [DIGIT_W-1:0] d);
    bit taken;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_range_low  = lo;
    in_range_high = hi;
    in_digit      = d;
    taken = 1'b0;
    while (!taken) begin
      #1;
      taken = !in_stall;
      @(posedge clk);
      if (taken) begin
        want_fifo[fifo_wr % FIFO_DEPTH] = assign_and_value(lo, hi, d);
        fifo_wr++;
        items_sent++;
        idle_cycles = 0;
      end
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (fifo_count() != 0) @(negedge clk);
    repeat (shadow_len + 8) @(negedge clk);
  endtask

  task automatic write_length(input logic [POS_W-1:0] v);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    idle_cycles = 0;
    restore_ones(v);
    lengths_used++;
  endtask

  task automatic send_legal(input int unsigned len);
    int unsigned a;
    int unsigned b;
    a = $urandom_range(1, len);
    b = $urandom_range(a, len);
    send_item(POS_W'(a), POS_W'(b), DIGIT_W'($urandom_range(1, 9)));
  endtask

  task automatic test_directed();
    send_item(13'd1, 13'd4096, 4'd9);
    send_item(13'd1, 13'd1, 4'd0);
    send_item(13'd4096, 13'd4096, 4'd5);
    send_item(13'd20, 13'd10, 4'd3);
    send_item(13'd5000, 13'd6000, 4'd7);
    send_item(13'd4000, 13'd8191, 4'd2);
    send_item(13'd1, 13'd100, 4'd15);
    send_item(13'd0, 13'd0, 4'd4);
    send_item(13'd0, 13'd3, 4'd8);
    send_item(13'd8191, 13'd8191, 4'd1);
    send_item(13'd2048, 13'd2049, 4'd10);
    send_item(13'd1, 13'd4096, 4'd1);
  endtask

  task automatic test_length_extremes();
    write_length(13'd0);
    send_item(13'd1, 13'd1, 4'd9);
    send_item(13'd2, 13'd2, 4'd5);
    send_item(13'd0, 13'd8191, 4'd6);
    write_length(13'd8191);
    send_item(13'd4095, 13'd4096, 4'd3);
    write_length(13'd4096);
    send_item(13'd1, 13'd2048, 4'd7);
    write_length(13'd1);
    send_item(13'd1, 13'd1, 4'd2);
    write_length(13'd2);
    send_item(13'd2, 13'd9, 4'd9);
  endtask

  task automatic test_random_ranges();
    int unsigned len;
    for (int ph = 0; ph < 7; ph++) begin
      len = (ph == 6) ? $urandom_range(200, 600) : $urandom_range(1, 40);
      write_length(POS_W'(len));
      for (int k = 0; k < 55; k++) begin
        if ($urandom_range(0, 4) == 0)
          send_item(POS_W'($urandom), POS_W'($urandom), DIGIT_W'($urandom));
        else
          send_legal(len);
      end
    end
  endtask

  task automatic test_backpressure();
    write_length(13'd16);
    hold_cycles = 400;
    quiet = 1'b1;
    for (int k = 0; k < 20; k++) send_legal(16);
    quiet = 1'b0;
  endtask

  task automatic test_no_idle();
    write_length(13'd24);
    quiet = 1'b1;
    for (int k = 0; k < 60; k++) send_legal(24);
  endtask

  // result side stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall = 1'b1;
      hold_cycles = $urandom_range(0, 18);
    end else begin
      out_stall = 1'b0;
    end
  end

  // result check
  always @(negedge clk) begin
    logic [VAL_W-1:0] got;
    logic [VAL_W-1:0] want;
    bit               fire;
    #2;
    fire = rst_n && out_valid && !out_stall;
    got  = out_number_mod_p;
    if (fire) begin
      @(posedge clk);
      values_seen++;
      idle_cycles = 0;
      if (fifo_count() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = want_fifo[fifo_rd % FIFO_DEPTH];
        fifo_rd++;
        if (got !== want) begin
          $display("%0t: number_mod_p mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_range_low = '0;
    in_range_high = '0;
    in_digit = '0;
    out_stall = 1'b0;
    fifo_wr = 0;
    fifo_rd = 0;
    errors = 0;
    items_sent = 0;
    values_seen = 0;
    lengths_used = 1;
    idle_cycles = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    restore_ones(13'd4096);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_length_extremes();
    test_random_ranges();
    test_backpressure();
    test_no_idle();
    wait_drained();

    $display("covered %0d range assignments over %0d length settings, %0d results checked",
             items_sent, lengths_used, values_seen);
    $display("including clamped lengths, reversed, outside, clipped ranges and bad digits");
    if (errors == 0 && fifo_count() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
